// ===== sv/tcf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared types, constants and helpers of the tilt complementary filter.
// ----------------------------------------------------------------------------
package tcf_pkg;

  // number of cordic micro-rotations
  localparam int CORDIC_STEPS = 14;
  // serial multiplier length, one multiplier bit per cycle
  localparam int MUL_LEN = 16;
  // first phase runs cordic and the rate multiply side by side
  localparam int PH1_LEN = (CORDIC_STEPS > MUL_LEN) ? CORDIC_STEPS : MUL_LEN;
  localparam int CNT_W = 5;
  localparam int TABLE_LEN = 24;

  // cordic datapath widths
  localparam int XY_W = 27;
  localparam int Z_W = 28;
  localparam int PRESCALE = 8;
  localparam logic signed [Z_W-1:0] PI_Z = 28'sd52707179;
  // angle loaded when resting on a side, pi/4 in q4.11
  localparam logic signed [15:0] SIDE_TILT = 16'sd1608;

  // serial product widths
  localparam int P1_W = 33;
  localparam int P2_W = 34;

  typedef enum logic [2:0] {
    CFG_IMU_ENABLE,
    CFG_RATE_BIAS,
    CFG_SAMPLE_PERIOD,
    CFG_BLEND_GAIN,
    CFG_SIDE_THRESHOLD
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_UPSIDE_DOWN,
    ST_NOT_FLAT,
    ST_IMU_OFF
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_PRED,
    S_BLEND,
    S_DONE
  } state_t;

  // arctangent of 2^-i in q.24 radians
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [CNT_W-1:0] i);
    logic signed [Z_W-1:0] v;
    begin
      case (i)
        5'd0: v = 28'sd13176795;
        5'd1: v = 28'sd7778716;
        5'd2: v = 28'sd4110060;
        5'd3: v = 28'sd2086331;
        5'd4: v = 28'sd1047214;
        5'd5: v = 28'sd524117;
        5'd6: v = 28'sd262123;
        5'd7: v = 28'sd131069;
        5'd8: v = 28'sd65536;
        5'd9: v = 28'sd32768;
        5'd10: v = 28'sd16384;
        5'd11: v = 28'sd8192;
        5'd12: v = 28'sd4096;
        5'd13: v = 28'sd2048;
        5'd14: v = 28'sd1024;
        5'd15: v = 28'sd512;
        5'd16: v = 28'sd256;
        5'd17: v = 28'sd128;
        5'd18: v = 28'sd64;
        5'd19: v = 28'sd32;
        5'd20: v = 28'sd16;
        5'd21: v = 28'sd8;
        5'd22: v = 28'sd4;
        5'd23: v = 28'sd2;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  // clamp to signed 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    begin
      if (v > 32'sd32767) r = 16'sd32767;
      else if (v < -32'sd32768) r = -16'sd32768;
      else r = v[15:0];
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// ===== sv/tcf_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcf channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface tcf_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic signed [15:0] gyro_rate;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  modport source (output valid, cmd, gyro_rate, accel_x, accel_y, input ready);
  modport sink (input valid, cmd, gyro_rate, accel_x, accel_y, output ready);
endinterface

interface tcf_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] angle;
  logic signed [15:0] rate;
  logic [1:0] status;
  modport source (output valid, angle, rate, status, input ready);
  modport sink (input valid, angle, rate, status, output ready);
endinterface
`default_nettype wire

// ===== sv/tilt_complementary_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_complementary_filter
// Gyro/accelerometer complementary filter keeping one tilt angle estimate.
// ----------------------------------------------------------------------------
// One item at a time. A filter step runs S_RUN, where the iterative cordic
// atan2 runs next to the bit-serial rate x period multiply, then S_PRED,
// which forms the prediction, then S_BLEND, which runs the bit-serial error
// x gain multiply, then S_DONE, which writes the result register. A
// classification or a step with the sensor disabled goes from the transfer
// straight to S_DONE. The input is ready again in the cycle the result
// appears, so a new item is taken only once the last one is written.
// The result register lets the next item be taken while a result
// still waits on the output side; that item then holds in S_DONE
// until the result register is free.
module tilt_complementary_filter (
  input  wire logic          clk,
  input  wire logic          rst_n,
  tcf_in_if.sink             in_ch,
  tcf_out_if.source          out_ch,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_data
);
  import tcf_pkg::*;

  // configuration registers
  logic              imu_enable_r;
  logic signed [15:0] rate_bias_r;
  logic [15:0]       sample_period_r;
  logic [15:0]       blend_gain_r;
  logic [14:0]       side_threshold_r;

  // filter state
  logic signed [15:0] tilt_r;
  logic signed [15:0] rate_r;
  logic [1:0]         status_r;
  logic               step_r;

  // sequencer
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r;

  // cordic registers
  logic signed [XY_W-1:0] x_r, y_r;
  logic signed [Z_W-1:0]  z_r;
  logic                   zero_r;

  // serial multipliers
  logic signed [P1_W-1:0] acc1_r, mc1_r;
  logic [15:0]            mp1_r;
  logic signed [P2_W-1:0] acc2_r, mc2_r;
  logic [15:0]            mp2_r;
  logic signed [15:0]     pred_r;

  // result register
  logic               out_valid_r;
  logic signed [15:0] out_angle_r, out_rate_r;
  logic [1:0]         out_status_r;

  logic in_xfer, out_free;
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.angle  = out_angle_r;
  assign out_ch.rate   = out_rate_r;
  assign out_ch.status = out_status_r;

  // accept-time values
  logic signed [16:0]     rate_diff;
  logic signed [15:0]     rate_sat;
  logic signed [XY_W-1:0] x_init, y_init;
  logic signed [15:0]     ax_mag;
  always_comb begin
    rate_diff = 17'(in_ch.gyro_rate) - 17'(rate_bias_r);
    rate_sat  = sat16(32'(rate_diff));
    x_init    = {{(XY_W-16-PRESCALE){in_ch.accel_y[15]}}, in_ch.accel_y, {PRESCALE{1'b0}}};
    y_init    = {{(XY_W-16-PRESCALE){in_ch.accel_x[15]}}, in_ch.accel_x, {PRESCALE{1'b0}}};
    ax_mag    = in_ch.accel_x[15] ? -in_ch.accel_x : in_ch.accel_x;
  end

  // one cordic micro-rotation
  logic signed [XY_W-1:0] xs, ys;
  logic signed [Z_W-1:0]  atan_i;
  always_comb begin
    xs     = x_r >>> cnt_r;
    ys     = y_r >>> cnt_r;
    atan_i = atan_entry(cnt_r);
  end

  // prediction and angle error
  logic signed [P1_W-1:0] r1;
  logic signed [18:0]     pred_sum;
  logic signed [15:0]     pred;
  logic signed [Z_W-1:0]  zr;
  logic signed [15:0]     meas;
  logic signed [16:0]     err;
  always_comb begin
    r1       = (acc1_r + P1_W'(16384)) >>> 15;
    pred_sum = 19'(tilt_r) + r1[18:0];
    pred     = sat16(32'(pred_sum));
    zr       = (z_r + Z_W'(4096)) >>> 13;
    meas     = zero_r ? 16'sd0 : sat16(32'(zr));
    err      = 17'(meas) - 17'(pred);
  end

  // blended angle
  logic signed [P2_W-1:0] r2;
  logic signed [19:0]     fin_sum;
  logic signed [15:0]     fin_angle;
  always_comb begin
    r2        = (acc2_r + P2_W'(32768)) >>> 16;
    fin_sum   = 20'(pred_r) + r2[19:0];
    fin_angle = sat16(32'(fin_sum));
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (imu_enable_r && !in_ch.cmd) state_nxt = S_RUN;
          else state_nxt = S_DONE;
        end
      end
      S_RUN: begin
        if (cnt_r == CNT_W'(PH1_LEN - 1)) state_nxt = S_PRED;
      end
      S_PRED: state_nxt = S_BLEND;
      S_BLEND: begin
        if (cnt_r == CNT_W'(MUL_LEN - 1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imu_enable_r     <= 1'b0;
      rate_bias_r      <= '0;
      sample_period_r  <= 16'd655;
      blend_gain_r     <= 16'd13107;
      side_threshold_r <= 15'd10425;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMU_ENABLE:     imu_enable_r     <= cfg_data[0];
        CFG_RATE_BIAS:      rate_bias_r      <= cfg_data;
        CFG_SAMPLE_PERIOD:  sample_period_r  <= cfg_data;
        CFG_BLEND_GAIN:     blend_gain_r     <= cfg_data;
        CFG_SIDE_THRESHOLD: side_threshold_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // filter state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tilt_r      <= '0;
      rate_r      <= '0;
      status_r    <= ST_OK;
      step_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // load a finished item, else empty the slot on a transfer
      if (state_r == S_DONE && out_free) begin
        out_valid_r  <= 1'b1;
        out_angle_r  <= step_r ? fin_angle : tilt_r;
        out_rate_r   <= rate_r;
        out_status_r <= status_r;
        if (step_r) tilt_r <= fin_angle;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_IDLE && in_xfer) begin
        if (!imu_enable_r) begin
          step_r   <= 1'b0;
          status_r <= ST_IMU_OFF;
        end else if (!in_ch.cmd) begin
          step_r   <= 1'b1;
          status_r <= ST_OK;
          rate_r   <= rate_sat;
        end else begin
          step_r <= 1'b0;
          if (in_ch.accel_y[15]) begin
            status_r <= ST_UPSIDE_DOWN;
          end else if ($unsigned(ax_mag) < {1'b0, side_threshold_r}) begin
            status_r <= ST_NOT_FLAT;
          end else begin
            status_r <= ST_OK;
            tilt_r   <= in_ch.accel_x[15] ? -SIDE_TILT : SIDE_TILT;
          end
        end
      end
    end
  end

  // cordic and serial multiply datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        cnt_r  <= '0;
        zero_r <= (in_ch.accel_x == 16'sd0) && (in_ch.accel_y == 16'sd0);
        if (in_ch.accel_y[15]) begin
          x_r <= -x_init;
          y_r <= -y_init;
          z_r <= in_ch.accel_x[15] ? -PI_Z : PI_Z;
        end else begin
          x_r <= x_init;
          y_r <= y_init;
          z_r <= '0;
        end
        acc1_r <= '0;
        mc1_r  <= P1_W'(rate_sat);
        mp1_r  <= sample_period_r;
      end
      S_RUN: begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r < CNT_W'(CORDIC_STEPS)) begin
          if (!y_r[XY_W-1]) begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + atan_i;
          end else begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - atan_i;
          end
        end
        if (cnt_r < CNT_W'(MUL_LEN)) begin
          if (mp1_r[0]) acc1_r <= acc1_r + mc1_r;
          mc1_r <= mc1_r <<< 1;
          mp1_r <= mp1_r >> 1;
        end
      end
      S_PRED: begin
        cnt_r  <= '0;
        pred_r <= pred;
        acc2_r <= '0;
        mc2_r  <= P2_W'(err);
        mp2_r  <= blend_gain_r;
      end
      S_BLEND: begin
        cnt_r <= cnt_r + 1'b1;
        if (mp2_r[0]) acc2_r <= acc2_r + mc2_r;
        mc2_r <= mc2_r <<< 1;
        mp2_r <= mp2_r >> 1;
      end
      S_DONE: ;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/tcf_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcf_sva
// Port-level checks of the tilt complementary filter.
// ----------------------------------------------------------------------------
module tcf_sva (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_angle,
  input wire logic [1:0]  out_status
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_angle) && $stable(out_status))
    else $error("stalled result changed");

  // one item in flight: no second transfer right after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // a result never appears in the cycle after a transfer
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early");

endmodule

bind tilt_complementary_filter tcf_sva u_tcf_sva (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_angle  (out_ch.angle),
  .out_status (out_ch.status)
);
`default_nettype wire
